/* hw/rtl/atrt_pkg.sv */
// ----------------------------------------------------------------------------
// atrt_pkg
// Shared constants, codes and controller/datapath interface types for the
// acknowledged-datagram tracking table.
// ----------------------------------------------------------------------------
package atrt_pkg;

   localparam int SLOTS      = 16;
   localparam int SLOT_W     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CNT_W      = $clog2(SLOTS + 1);
   localparam int ID_W       = 32;
   localparam int TMO_W      = 16;
   localparam int KIND_W     = 2;
   localparam int STATUS_W   = 4;
   localparam int SLOT_OUT_W = 6;

   localparam logic [CNT_W-1:0] SLOTS_CNT = CNT_W'(SLOTS);
   localparam logic [TMO_W-1:0] TMO_RESET = TMO_W'(2);

   localparam logic [KIND_W-1:0] KIND_SEND = 2'd0;
   localparam logic [KIND_W-1:0] KIND_ACK  = 2'd1;
   localparam logic [KIND_W-1:0] KIND_DATA = 2'd2;
   localparam logic [KIND_W-1:0] KIND_TICK = 2'd3;

   localparam logic [STATUS_W-1:0] ST_SENT      = 4'd0;
   localparam logic [STATUS_W-1:0] ST_FULL      = 4'd1;
   localparam logic [STATUS_W-1:0] ST_ACK_OK    = 4'd2;
   localparam logic [STATUS_W-1:0] ST_ACK_MISS  = 4'd3;
   localparam logic [STATUS_W-1:0] ST_NEW       = 4'd4;
   localparam logic [STATUS_W-1:0] ST_DUP       = 4'd5;
   localparam logic [STATUS_W-1:0] ST_NEW_UNREC = 4'd6;
   localparam logic [STATUS_W-1:0] ST_RETX      = 4'd7;
   localparam logic [STATUS_W-1:0] ST_IDLE      = 4'd8;

   typedef struct packed {
      logic              load;
      logic              rd_en;
      logic [SLOT_W-1:0] rd_addr;
      logic              eval;
      logic [SLOT_W-1:0] eval_idx;
      logic              flush;
   } atrt_cmd_type;

   typedef struct packed {
      logic done_hit;
   } atrt_sts_type;

endpackage

/* hw/rtl/atrt_ram.sv */
// ----------------------------------------------------------------------------
// atrt_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module atrt_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                         wr_data,
   input  logic                                     rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* hw/rtl/atrt_ctrl.sv */
// ----------------------------------------------------------------------------
// atrt_ctrl
// Controller: accepts an item, walks the slot index one slot per cycle and
// closes the item on an early hit or with a final flush cycle.
// ----------------------------------------------------------------------------
module atrt_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   output atrt_pkg::atrt_cmd_type cmd,
   input  atrt_pkg::atrt_sts_type sts
);
   import atrt_pkg::*;

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_SCAN  = 2'd1;
   localparam logic [1:0] S_FLUSH = 2'd2;

   logic [1:0]        state_ff, state_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              eval_ff, eval_in;
   logic [SLOT_W-1:0] eval_idx_ff, eval_idx_in;
   logic              load;
   logic              rd_issue;

   assign busy     = (state_ff != S_IDLE);
   assign load     = start && (state_ff == S_IDLE);
   assign rd_issue = (state_ff == S_SCAN) && (cnt_ff < SLOTS_CNT);

   always_comb begin
      cmd.load     = load;
      cmd.rd_en    = rd_issue;
      cmd.rd_addr  = cnt_ff[SLOT_W-1:0];
      cmd.eval     = eval_ff;
      cmd.eval_idx = eval_idx_ff;
      cmd.flush    = (state_ff == S_FLUSH);
   end

   always_comb begin
      state_in    = state_ff;
      cnt_in      = cnt_ff;
      eval_in     = rd_issue && !sts.done_hit;
      eval_idx_in = cnt_ff[SLOT_W-1:0];
      case (state_ff)
         S_IDLE: begin
            if (load) begin
               state_in = S_SCAN;
               cnt_in   = '0;
            end
         end
         S_SCAN: begin
            if (sts.done_hit) begin
               state_in = S_IDLE;
            end else if (cnt_ff == SLOTS_CNT) begin
               state_in = S_FLUSH;
            end else begin
               cnt_in = cnt_ff + CNT_W'(1);
            end
         end
         S_FLUSH: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
         eval_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         eval_ff  <= eval_in;
      end
      eval_idx_ff <= eval_idx_in;
   end

   a_eval_in_scan: assert property (@(posedge clock) disable iff (reset)
      eval_ff |-> (state_ff == S_SCAN))
      else $error("Slot evaluated outside of a scan.");

   a_load_starts_scan: assert property (@(posedge clock) disable iff (reset)
      load |=> (state_ff == S_SCAN) && (cnt_ff == '0) && !eval_ff)
      else $error("Accepted item did not start a fresh scan.");

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN) |-> (cnt_ff <= SLOTS_CNT))
      else $error("Slot counter ran past the table.");

   a_flush_after_full_scan: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FLUSH) |-> $past(cnt_ff == SLOTS_CNT))
      else $error("Flush without a complete scan.");

endmodule

/* hw/rtl/atrt_datapath.sv */
// ----------------------------------------------------------------------------
// atrt_datapath
// Datapath: slot tables, identifier and time counters, timeout register,
// per-slot compare logic and the registered result port.
// ----------------------------------------------------------------------------
module atrt_datapath (
   input  logic                               clock,
   input  logic                               reset,
   input  atrt_pkg::atrt_cmd_type             cmd,
   output atrt_pkg::atrt_sts_type             sts,
   input  logic [atrt_pkg::KIND_W-1:0]        req_kind,
   input  logic [atrt_pkg::ID_W-1:0]          req_msg_id,
   input  logic                               csr_write,
   input  logic [atrt_pkg::TMO_W-1:0]         csr_data,
   output logic                               rsp_valid,
   output logic [atrt_pkg::STATUS_W-1:0]      rsp_status,
   output logic [atrt_pkg::SLOT_OUT_W-1:0]    rsp_slot,
   output logic [atrt_pkg::ID_W-1:0]          rsp_out_id,
   output logic                               rsp_last
);
   import atrt_pkg::*;

   logic [KIND_W-1:0]     kind_ff;
   logic [ID_W-1:0]       id_ff;
   logic [ID_W-1:0]       next_ident_ff;
   logic [ID_W-1:0]       now_ff;
   logic [TMO_W-1:0]      tmo_ff;
   logic [SLOTS-1:0]      pv_ff;
   logic [SLOTS-1:0]      sv_ff;
   logic                  free_found_ff;
   logic [SLOT_W-1:0]     free_idx_ff;
   logic                  hold_vld_ff;
   logic [SLOT_W-1:0]     hold_slot_ff;
   logic [ID_W-1:0]       hold_id_ff;
   logic                  rsp_valid_ff;
   logic [STATUS_W-1:0]   rsp_status_ff;
   logic [SLOT_OUT_W-1:0] rsp_slot_ff;
   logic [ID_W-1:0]       rsp_out_id_ff;
   logic                  rsp_last_ff;

   logic [ID_W-1:0]       pid_rd, pst_rd, sid_rd;
   logic                  pid_we, pst_we, sid_we;
   logic [ID_W-1:0]       elapsed;
   logic                  pv_e, sv_e;
   logic                  overdue, match_ack, dup;
   logic                  done_hit, tick_hit;
   logic                  emit;
   logic [STATUS_W-1:0]   em_status;
   logic [SLOT_OUT_W-1:0] em_slot;
   logic [ID_W-1:0]       em_id;
   logic                  em_last;

   atrt_ram #(.WIDTH(ID_W), .DEPTH(SLOTS)) u_pend_ident (
      .clock   (clock),
      .wr_en   (pid_we),
      .wr_addr (cmd.eval_idx),
      .wr_data (next_ident_ff),
      .rd_en   (cmd.rd_en),
      .rd_addr (cmd.rd_addr),
      .rd_data (pid_rd)
   );

   atrt_ram #(.WIDTH(ID_W), .DEPTH(SLOTS)) u_pend_stamp (
      .clock   (clock),
      .wr_en   (pst_we),
      .wr_addr (cmd.eval_idx),
      .wr_data (now_ff),
      .rd_en   (cmd.rd_en),
      .rd_addr (cmd.rd_addr),
      .rd_data (pst_rd)
   );

   atrt_ram #(.WIDTH(ID_W), .DEPTH(SLOTS)) u_seen_ident (
      .clock   (clock),
      .wr_en   (sid_we),
      .wr_addr (free_idx_ff),
      .wr_data (id_ff),
      .rd_en   (cmd.rd_en),
      .rd_addr (cmd.rd_addr),
      .rd_data (sid_rd)
   );

   assign pv_e      = pv_ff[cmd.eval_idx];
   assign sv_e      = sv_ff[cmd.eval_idx];
   assign elapsed   = now_ff - pst_rd;
   assign overdue   = (elapsed >= {{(ID_W-TMO_W){1'b0}}, tmo_ff});
   assign match_ack = pv_e && (pid_rd == id_ff);
   assign dup       = sv_e && (sid_rd == id_ff);

   assign done_hit = cmd.eval && (((kind_ff == KIND_SEND) && !pv_e) ||
                                  ((kind_ff == KIND_ACK) && match_ack) ||
                                  ((kind_ff == KIND_DATA) && dup));
   assign tick_hit = cmd.eval && (kind_ff == KIND_TICK) && pv_e && overdue;

   assign sts.done_hit = done_hit;

   always_comb begin
      emit      = 1'b0;
      em_status = ST_IDLE;
      em_slot   = '0;
      em_id     = '0;
      em_last   = 1'b1;
      pid_we    = 1'b0;
      pst_we    = 1'b0;
      sid_we    = 1'b0;
      if (done_hit) begin
         emit    = 1'b1;
         em_slot = SLOT_OUT_W'(cmd.eval_idx);
         em_id   = id_ff;
         case (kind_ff)
            KIND_SEND: begin
               em_status = ST_SENT;
               em_id     = next_ident_ff;
               pid_we    = 1'b1;
               pst_we    = 1'b1;
            end
            KIND_ACK: begin
               em_status = ST_ACK_OK;
            end
            default: begin
               em_status = ST_DUP;
               em_slot   = '0;
            end
         endcase
      end
      if (tick_hit) begin
         pst_we = 1'b1;
         if (hold_vld_ff) begin
            emit      = 1'b1;
            em_status = ST_RETX;
            em_slot   = SLOT_OUT_W'(hold_slot_ff);
            em_id     = hold_id_ff;
            em_last   = 1'b0;
         end
      end
      if (cmd.flush) begin
         emit = 1'b1;
         case (kind_ff)
            KIND_SEND: begin
               em_status = ST_FULL;
            end
            KIND_ACK: begin
               em_status = ST_ACK_MISS;
               em_id     = id_ff;
            end
            KIND_DATA: begin
               em_id = id_ff;
               if (free_found_ff) begin
                  em_status = ST_NEW;
                  sid_we    = 1'b1;
               end else begin
                  em_status = ST_NEW_UNREC;
               end
            end
            default: begin
               if (hold_vld_ff) begin
                  em_status = ST_RETX;
                  em_slot   = SLOT_OUT_W'(hold_slot_ff);
                  em_id     = hold_id_ff;
               end else begin
                  em_status = ST_IDLE;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         next_ident_ff <= '0;
         now_ff        <= '0;
         tmo_ff        <= TMO_RESET;
         pv_ff         <= '0;
         sv_ff         <= '0;
         free_found_ff <= 1'b0;
         hold_vld_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         rsp_valid_ff <= emit;
         if (csr_write) begin
            tmo_ff <= csr_data;
         end
         if (cmd.load) begin
            free_found_ff <= 1'b0;
            hold_vld_ff   <= 1'b0;
            if (req_kind == KIND_SEND) begin
               next_ident_ff <= next_ident_ff + ID_W'(1);
            end
            if (req_kind == KIND_TICK) begin
               now_ff <= now_ff + ID_W'(1);
            end
         end
         if (done_hit && (kind_ff == KIND_SEND)) begin
            pv_ff[cmd.eval_idx] <= 1'b1;
         end
         if (done_hit && (kind_ff == KIND_ACK)) begin
            pv_ff[cmd.eval_idx] <= 1'b0;
         end
         if (cmd.eval && (kind_ff == KIND_DATA) && !sv_e && !free_found_ff) begin
            free_found_ff <= 1'b1;
         end
         if (sid_we) begin
            sv_ff[free_idx_ff] <= 1'b1;
         end
         if (tick_hit) begin
            hold_vld_ff <= 1'b1;
         end
         if (cmd.flush) begin
            hold_vld_ff <= 1'b0;
         end
      end
      if (cmd.load) begin
         kind_ff <= req_kind;
         id_ff   <= req_msg_id;
      end
      if (cmd.eval && (kind_ff == KIND_DATA) && !sv_e && !free_found_ff) begin
         free_idx_ff <= cmd.eval_idx;
      end
      if (tick_hit) begin
         hold_slot_ff <= cmd.eval_idx;
         hold_id_ff   <= pid_rd;
      end
      rsp_status_ff <= em_status;
      rsp_slot_ff   <= em_slot;
      rsp_out_id_ff <= em_id;
      rsp_last_ff   <= em_last;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_slot   = rsp_slot_ff;
   assign rsp_out_id = rsp_out_id_ff;
   assign rsp_last   = rsp_last_ff;

endmodule

/* hw/rtl/ack_retransmit_tracking_table.sv */
// ----------------------------------------------------------------------------
// ack_retransmit_tracking_table
// Pending-message and seen-identifier tracking with tick-driven retransmit.
// ----------------------------------------------------------------------------
// An item is a transfer at a rising edge with start high and busy low. The
// block then walks its slot tables one slot per cycle through the read port
// of the slot RAMs. A send, an ack or a duplicate data item that hits at a
// slot ends its walk there; any item that walks all SLOTS slots, which every
// tick does, ends in the flush state. Busy stays high until the item is
// closed, so no new transfer is taken before the last one ends. Each result
// is shown for exactly one cycle with rsp_valid high and must be taken then,
// since the block cannot be stalled on its result side. A tick gives one
// retransmit result per overdue slot in ascending slot order, or one idle
// result, and rsp_last marks the final result of every item. Timeout writes
// on the csr channel are always ready and should be made while the block is
// idle.
module ack_retransmit_tracking_table (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic [atrt_pkg::KIND_W-1:0]     req_kind,
   input  logic [atrt_pkg::ID_W-1:0]       req_msg_id,
   output logic                            rsp_valid,
   output logic [atrt_pkg::STATUS_W-1:0]   rsp_status,
   output logic [atrt_pkg::SLOT_OUT_W-1:0] rsp_slot,
   output logic [atrt_pkg::ID_W-1:0]       rsp_out_id,
   output logic                            rsp_last,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [atrt_pkg::TMO_W-1:0]      csr_data
);
   import atrt_pkg::*;

   atrt_cmd_type cmd;
   atrt_sts_type sts;

   assign csr_ready = 1'b1;

   atrt_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .cmd   (cmd),
      .sts   (sts)
   );

   atrt_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .req_kind   (req_kind),
      .req_msg_id (req_msg_id),
      .csr_write  (csr_valid && csr_ready),
      .csr_data   (csr_data),
      .rsp_valid  (rsp_valid),
      .rsp_status (rsp_status),
      .rsp_slot   (rsp_slot),
      .rsp_out_id (rsp_out_id),
      .rsp_last   (rsp_last)
   );

endmodule
